FILE: src/mme_pkg.sv
// Shared types and constants for the matrix multiply engine.
package mme_pkg;

    localparam int DIM_DEFAULT = 16;
    localparam int ELEM_W      = 16;
    localparam int PROD_W      = 2 * ELEM_W;
    localparam int ACC_W       = 36;
    localparam int RC_W        = 4;

    localparam logic REQ_WRITE   = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic row_end;
    } mac_flags_t;

endpackage

FILE: src/matrix_multiply_engine.sv
// Matrix multiply engine: element stores, row sequencer and shared multiply-accumulate.
//
// Usage: present one item on req_type, elem_row, elem_col, a_value and
// b_value with start high; the beat is taken at the clock edge where start
// is high and busy is low.
// A write beat (req_type 0) stores a_value into A and b_value into B at
// (elem_row, elem_col) in that cycle; busy stays low, so writes can
// stream one per cycle. Writes outside the DIM x DIM square are dropped.
// A compute beat (req_type 1) names a result row. The sequencer then walks
// every column j and every term k through a single 16x16 multiplier and one
// 36-bit accumulator, one term per cycle, limited by the one read port of
// each element store. Each term passes through the pipeline stages store
// read, multiply and accumulate; busy goes high after the accepted beat and
// is low again in the cycle the final result of the row is shown.
// Results appear in column order, each on out_col/product_value/last_of_row
// for exactly one cycle with result_valid high; last_of_row marks the final
// column. The receiver cannot stall the block, so results are never held.
// A compute for a row of DIM or more is taken and produces nothing.
// Reset clears the sequencer and the result strobe; the element stores are
// not cleared and must be written before they are read.
module matrix_multiply_engine #(
    parameter int DIM = mme_pkg::DIM_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               req_type,
    input  logic [mme_pkg::RC_W-1:0]           elem_row,
    input  logic [mme_pkg::RC_W-1:0]           elem_col,
    input  logic signed [mme_pkg::ELEM_W-1:0]  a_value,
    input  logic signed [mme_pkg::ELEM_W-1:0]  b_value,
    output logic                               result_valid,
    output logic [mme_pkg::RC_W-1:0]           out_col,
    output logic signed [mme_pkg::ACC_W-1:0]   product_value,
    output logic                               last_of_row
);

    localparam int IDX_W  = $clog2(DIM);
    localparam int DEPTH  = DIM * DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DIM - 1);

    // Element stores, one read port each
    logic signed [mme_pkg::ELEM_W-1:0] a_mem [DEPTH];
    logic signed [mme_pkg::ELEM_W-1:0] b_mem [DEPTH];

    mme_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;

    logic accept;
    logic row_ok;
    logic col_ok;
    logic wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] a_rd_addr;
    logic [ADDR_W-1:0] b_rd_addr;

    mme_pkg::mac_flags_t iss_flags;
    mme_pkg::mac_flags_t s1_flags_reg;
    mme_pkg::mac_flags_t s2_flags_reg;
    logic [IDX_W-1:0] s1_col_reg;
    logic [IDX_W-1:0] s2_col_reg;

    logic signed [mme_pkg::ELEM_W-1:0] a_rd_reg;
    logic signed [mme_pkg::ELEM_W-1:0] b_rd_reg;
    logic signed [mme_pkg::PROD_W-1:0] prod_reg;
    logic signed [mme_pkg::ACC_W-1:0]  acc_reg;
    logic signed [mme_pkg::ACC_W-1:0]  acc_next;

    logic                              result_valid_reg;
    logic [mme_pkg::RC_W-1:0]          out_col_reg;
    logic signed [mme_pkg::ACC_W-1:0]  product_value_reg;
    logic                              last_of_row_reg;

    assign busy   = (state_reg != mme_pkg::ST_IDLE);
    assign accept = start && !busy;
    assign row_ok = (32'(elem_row) < DIM);
    assign col_ok = (32'(elem_col) < DIM);
    assign wr_en  = accept && (req_type == mme_pkg::REQ_WRITE) && row_ok && col_ok;

    // Row-major addressing: A walks along the row, B walks down the column
    assign wr_addr   = ADDR_W'(32'(elem_row) * DIM + 32'(elem_col));
    assign a_rd_addr = ADDR_W'(32'(row_reg) * DIM + 32'(k_reg));
    assign b_rd_addr = ADDR_W'(32'(k_reg) * DIM + 32'(j_reg));

    // Tag for the term issued this cycle
    always_comb
    begin
        iss_flags.valid   = (state_reg == mme_pkg::ST_RUN);
        iss_flags.first   = (k_reg == '0);
        iss_flags.last    = (k_reg == IDX_MAX);
        iss_flags.row_end = (k_reg == IDX_MAX) && (j_reg == IDX_MAX);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            a_mem[wr_addr] <= a_value;
            b_mem[wr_addr] <= b_value;
        end
        a_rd_reg <= a_mem[a_rd_addr];
        b_rd_reg <= b_mem[b_rd_addr];
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mme_pkg::ST_IDLE;
            row_reg   <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        case (state_reg)
            mme_pkg::ST_IDLE:
            begin
                if (start && (req_type == mme_pkg::REQ_COMPUTE) && row_ok)
                begin
                    state_next = mme_pkg::ST_RUN;
                    row_next   = IDX_W'(elem_row);
                    j_next     = '0;
                    k_next     = '0;
                end
            end
            mme_pkg::ST_RUN:
            begin
                // Advance k every cycle, j on each wrap of k
                if (k_reg == IDX_MAX)
                begin
                    k_next = '0;
                    if (j_reg == IDX_MAX)
                    begin
                        j_next     = '0;
                        state_next = mme_pkg::ST_DRAIN;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            mme_pkg::ST_DRAIN:
            begin
                if (s2_flags_reg.valid && s2_flags_reg.row_end)
                begin
                    state_next = mme_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mme_pkg::ST_IDLE;
            end
        endcase
    end

    // MAC pipeline control: read stage, then multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_flags_reg     <= '0;
            s2_flags_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_flags_reg     <= iss_flags;
            s2_flags_reg     <= s1_flags_reg;
            result_valid_reg <= s2_flags_reg.valid && s2_flags_reg.last;
        end
    end

    // Restart the sum on the first term of each column
    assign acc_next = (s2_flags_reg.first ? '0 : acc_reg) + mme_pkg::ACC_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        s1_col_reg <= j_reg;
        s2_col_reg <= s1_col_reg;
        prod_reg   <= a_rd_reg * b_rd_reg;
        if (s2_flags_reg.valid)
        begin
            acc_reg <= acc_next;
        end
        if (s2_flags_reg.valid && s2_flags_reg.last)
        begin
            product_value_reg <= acc_next;
            out_col_reg       <= mme_pkg::RC_W'(s2_col_reg);
            last_of_row_reg   <= s2_flags_reg.row_end;
        end
    end

    assign result_valid  = result_valid_reg;
    assign out_col       = out_col_reg;
    assign product_value = product_value_reg;
    assign last_of_row   = last_of_row_reg;

`ifndef ASSERT_OFF
    a_compute_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == mme_pkg::REQ_COMPUTE) && row_ok) |=> busy)
        else $error("accepted compute did not raise busy");

    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mme_pkg::ST_IDLE) |-> (!s1_flags_reg.valid && !s2_flags_reg.valid))
        else $error("MAC pipeline holds terms while idle");

    a_row_end_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_of_row) |-> !busy)
        else $error("final result of a row shown while still busy");

    a_strobe_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("results strobed in adjacent cycles");
`endif

endmodule
